// File: rtl/mis_pkg.sv
// shared constants, payload types and controller/datapath interface types
package mis_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_BITS = 31;
    localparam int ADDR_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int LG_W       = $clog2(ADDR_W + 1);
    localparam int GW         = CNT_W + 1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } t_in_word;

    typedef struct packed {
        logic [VALUE_BITS-1:0] sorted_value;
        logic                  end_of_run;
        logic                  overflow;
    } t_out_word;

    typedef enum logic [1:0] {
        WS_IN,
        WS_A,
        WS_MRD,
        WS_PRD
    } t_wsel;

    typedef struct packed {
        logic              m_we;
        logic [ADDR_W-1:0] m_waddr;
        t_wsel             m_wsel;
        logic [ADDR_W-1:0] m_raddr;
        logic              p_we;
        logic [ADDR_W-1:0] p_waddr;
        logic [ADDR_W-1:0] p_raddr;
        logic              lat_a;
        logic              lat_key;
        logic              out_load;
        logic              out_end;
        logic              out_ovf;
    } t_dp_cmd;

    typedef struct packed {
        logic lt_a;
        logic lt_key;
    } t_dp_sts;

endpackage

// File: rtl/mis_ram.sv
// generic single write port, single read port ram with registered read
module mis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mis_dp.sv
// datapath: main and pending stores, compare registers and output register
module mis_dp (
    input  logic                       i_clk,
    input  logic [mis_pkg::VALUE_BITS-1:0] i_value,
    input  mis_pkg::t_dp_cmd           i_cmd,
    output mis_pkg::t_dp_sts           o_sts,
    output mis_pkg::t_out_word         o_out_word
);
    import mis_pkg::*;

    logic [VALUE_BITS-1:0] m_rdata;
    logic [VALUE_BITS-1:0] p_rdata;
    logic [VALUE_BITS-1:0] m_wdata;
    logic [VALUE_BITS-1:0] r_a;
    logic [VALUE_BITS-1:0] r_key;
    t_out_word             r_out;

    always_comb begin
        case (i_cmd.m_wsel)
            WS_IN:   m_wdata = i_value;
            WS_A:    m_wdata = r_a;
            WS_MRD:  m_wdata = m_rdata;
            WS_PRD:  m_wdata = p_rdata;
            default: m_wdata = i_value;
        endcase
    end

    mis_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_main (
        .i_clk   (i_clk),
        .i_we    (i_cmd.m_we),
        .i_waddr (i_cmd.m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (i_cmd.m_raddr),
        .o_rdata (m_rdata)
    );

    mis_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_pend (
        .i_clk   (i_clk),
        .i_we    (i_cmd.p_we),
        .i_waddr (i_cmd.p_waddr),
        .i_wdata (m_rdata),
        .i_raddr (i_cmd.p_raddr),
        .o_rdata (p_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_a) begin
            r_a <= m_rdata;
        end
        if (i_cmd.lat_key) begin
            r_key <= p_rdata;
        end
        if (i_cmd.out_load) begin
            r_out.sorted_value <= m_rdata;
            r_out.end_of_run   <= i_cmd.out_end;
            r_out.overflow     <= i_cmd.out_ovf;
        end
    end

    assign o_sts.lt_a   = (r_a < m_rdata);
    assign o_sts.lt_key = (r_key < m_rdata);
    assign o_out_word   = r_out;

endmodule

// File: rtl/mis_ctrl.sv
// controller: load, pair/swap passes, reinsertion levels and output sequencing
module mis_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_stall,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output mis_pkg::t_dp_cmd o_cmd,
    input  mis_pkg::t_dp_sts i_sts
);
    import mis_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE, S_SW_TEST, S_SW_RA, S_SW_CMP, S_SW_X0, S_SW_X1, S_SW_X2, S_SW_X3,
        S_SW_END, S_IL_START, S_IL_PAIR, S_CP0, S_CP1, S_CP2, S_IL_ODD, S_OD0,
        S_OD1, S_TL, S_TL1, S_IL_LOOP, S_IL_GEN, S_SR_INIT, S_SR_KEY, S_SR_TEST,
        S_SR_CMP, S_MV_TEST, S_MV_WR, S_CPY0, S_CPY1, S_IL_NEXT, S_OUT_RD,
        S_OUT_LD, S_OUT_WAIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count, r_n, r_span, r_i, r_j, r_mlen, r_pcnt, r_pc;
    logic [CNT_W-1:0] r_ii, r_jo, r_lo, r_hi, r_mid, r_at, r_src, r_k;
    logic [LG_W-1:0]  r_lg;
    logic [GW-1:0]    r_gj1, r_gj2, r_gval;
    logic             r_drop, r_out_valid;

    logic             in_acc, has_room;
    logic [CNT_W-1:0] count_new;
    logic [CNT_W:0]   i_2span, span2, n_minus_i;
    logic [CNT_W-1:0] a_ij, a_isj, a_mj, a_pj, a_km1, a_km1s, a_srcj, a_atj;
    logic [CNT_W-1:0] a_is, a_probe, a_key, mid_c, full_c, cnt_c, hi_c, j_inc;
    logic [GW-1:0]    jn_c, gmin_c;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign has_room  = (r_count < CNT_W'(MAX_ITEMS));
    assign count_new = has_room ? r_count + CNT_W'(1) : r_count;

    assign span2     = {r_span, 1'b0};
    assign i_2span   = {1'b0, r_i} + span2;
    assign n_minus_i = {1'b0, r_n} - {1'b0, r_i};
    assign a_ij      = r_i + r_j;
    assign a_is      = r_i + r_span;
    assign a_isj     = r_i + r_span + r_j;
    assign a_mj      = r_mlen + r_j;
    assign a_pj      = r_pcnt + r_j;
    assign a_km1     = r_k - CNT_W'(1);
    assign a_km1s    = r_k - CNT_W'(1) + r_span;
    assign a_srcj    = r_src + r_j;
    assign a_atj     = r_at + r_j;
    assign a_probe   = mid_c << r_lg;
    assign a_key     = r_jo << r_lg;
    assign j_inc     = r_j + CNT_W'(1);
    assign mid_c     = CNT_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign full_c    = r_mlen >> r_lg;
    assign cnt_c     = r_jo + r_ii;
    assign hi_c      = (cnt_c > full_c) ? full_c : cnt_c;
    assign jn_c      = r_gj2 + {r_gj1[GW-2:0], 1'b0};
    assign gmin_c    = (jn_c < {1'b0, r_pc}) ? jn_c : {1'b0, r_pc};

    always_comb begin
        o_cmd         = '0;
        o_cmd.m_wsel  = WS_MRD;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.m_we    = in_acc && has_room;
                o_cmd.m_waddr = r_count[ADDR_W-1:0];
                o_cmd.m_wsel  = WS_IN;
            end
            S_SW_TEST:  o_cmd.m_raddr = r_i[ADDR_W-1:0];
            S_SW_RA: begin
                o_cmd.m_raddr = a_is[ADDR_W-1:0];
                o_cmd.lat_a   = 1'b1;
            end
            S_SW_X0:    o_cmd.m_raddr = a_ij[ADDR_W-1:0];
            S_SW_X1: begin
                o_cmd.m_raddr = a_isj[ADDR_W-1:0];
                o_cmd.lat_a   = 1'b1;
            end
            S_SW_X2: begin
                o_cmd.m_we    = 1'b1;
                o_cmd.m_waddr = a_ij[ADDR_W-1:0];
            end
            S_SW_X3: begin
                o_cmd.m_we    = 1'b1;
                o_cmd.m_waddr = a_isj[ADDR_W-1:0];
                o_cmd.m_wsel  = WS_A;
            end
            S_CP0:      o_cmd.m_raddr = a_ij[ADDR_W-1:0];
            S_CP1: begin
                o_cmd.m_we    = 1'b1;
                o_cmd.m_waddr = a_mj[ADDR_W-1:0];
                o_cmd.m_raddr = a_isj[ADDR_W-1:0];
            end
            S_CP2, S_OD1: begin
                o_cmd.p_we    = 1'b1;
                o_cmd.p_waddr = a_pj[ADDR_W-1:0];
            end
            S_OD0:      o_cmd.m_raddr = a_ij[ADDR_W-1:0];
            S_TL:       o_cmd.m_raddr = r_i[ADDR_W-1:0];
            S_TL1: begin
                o_cmd.m_we    = 1'b1;
                o_cmd.m_waddr = r_mlen[ADDR_W-1:0];
            end
            S_SR_INIT:  o_cmd.p_raddr = a_key[ADDR_W-1:0];
            S_SR_KEY:   o_cmd.lat_key = 1'b1;
            S_SR_TEST:  o_cmd.m_raddr = a_probe[ADDR_W-1:0];
            S_MV_TEST:  o_cmd.m_raddr = a_km1[ADDR_W-1:0];
            S_MV_WR: begin
                o_cmd.m_we    = 1'b1;
                o_cmd.m_waddr = a_km1s[ADDR_W-1:0];
            end
            S_CPY0:     o_cmd.p_raddr = a_srcj[ADDR_W-1:0];
            S_CPY1: begin
                o_cmd.m_we    = 1'b1;
                o_cmd.m_waddr = a_atj[ADDR_W-1:0];
                o_cmd.m_wsel  = WS_PRD;
            end
            S_OUT_RD:   o_cmd.m_raddr = r_k[ADDR_W-1:0];
            S_OUT_LD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_end  = (r_k + CNT_W'(1) == r_n);
                o_cmd.out_ovf  = r_drop;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_count <= count_new;
                        if (!has_room) begin
                            r_drop <= 1'b1;
                        end
                        if (i_in_last) begin
                            r_n    <= count_new;
                            r_span <= CNT_W'(1);
                            r_lg   <= '0;
                            r_i    <= '0;
                            r_k    <= '0;
                            r_state <= (count_new < CNT_W'(2)) ? S_OUT_RD : S_SW_TEST;
                        end
                    end
                end
                S_SW_TEST: r_state <= (i_2span <= {1'b0, r_n}) ? S_SW_RA : S_SW_END;
                S_SW_RA:   r_state <= S_SW_CMP;
                S_SW_CMP: begin
                    if (i_sts.lt_a) begin
                        r_j     <= '0;
                        r_state <= S_SW_X0;
                    end else begin
                        r_i     <= i_2span[CNT_W-1:0];
                        r_state <= S_SW_TEST;
                    end
                end
                S_SW_X0: r_state <= S_SW_X1;
                S_SW_X1: r_state <= S_SW_X2;
                S_SW_X2: r_state <= S_SW_X3;
                S_SW_X3: begin
                    r_j <= j_inc;
                    if (j_inc == r_span) begin
                        r_i     <= i_2span[CNT_W-1:0];
                        r_state <= S_SW_TEST;
                    end else begin
                        r_state <= S_SW_X0;
                    end
                end
                S_SW_END: begin
                    if ({1'b0, r_n} <= span2) begin
                        r_state <= S_IL_START;
                    end else begin
                        r_span  <= span2[CNT_W-1:0];
                        r_lg    <= r_lg + LG_W'(1);
                        r_i     <= '0;
                        r_state <= S_SW_TEST;
                    end
                end
                S_IL_START: begin
                    r_i     <= '0;
                    r_mlen  <= '0;
                    r_pcnt  <= '0;
                    r_pc    <= '0;
                    r_state <= S_IL_PAIR;
                end
                S_IL_PAIR: begin
                    r_j     <= '0;
                    r_state <= (i_2span <= {1'b0, r_n}) ? S_CP0 : S_IL_ODD;
                end
                S_CP0: r_state <= S_CP1;
                S_CP1: r_state <= S_CP2;
                S_CP2: begin
                    r_j <= j_inc;
                    if (j_inc == r_span) begin
                        r_mlen  <= r_mlen + r_span;
                        r_pcnt  <= r_pcnt + r_span;
                        r_pc    <= r_pc + CNT_W'(1);
                        r_i     <= i_2span[CNT_W-1:0];
                        r_state <= S_IL_PAIR;
                    end else begin
                        r_state <= S_CP0;
                    end
                end
                S_IL_ODD: r_state <= ({1'b0, r_span} <= n_minus_i) ? S_OD0 : S_TL;
                S_OD0:    r_state <= S_OD1;
                S_OD1: begin
                    r_j <= j_inc;
                    if (j_inc == r_span) begin
                        r_pcnt  <= r_pcnt + r_span;
                        r_pc    <= r_pc + CNT_W'(1);
                        r_i     <= r_i + r_span;
                        r_state <= S_TL;
                    end else begin
                        r_state <= S_OD0;
                    end
                end
                S_TL: begin
                    if (r_i < r_n) begin
                        r_state <= S_TL1;
                    end else if (r_pc == '0) begin
                        r_state <= S_IL_NEXT;
                    end else begin
                        r_ii    <= '0;
                        r_gj1   <= GW'(1);
                        r_gj2   <= GW'(1);
                        r_gval  <= GW'(1);
                        r_state <= S_IL_LOOP;
                    end
                end
                S_TL1: begin
                    r_mlen  <= r_mlen + CNT_W'(1);
                    r_i     <= r_i + CNT_W'(1);
                    r_state <= S_TL;
                end
                S_IL_LOOP: begin
                    if (r_ii == '0) begin
                        r_at    <= '0;
                        r_src   <= '0;
                        r_k     <= r_mlen;
                        r_state <= S_MV_TEST;
                    end else if (r_ii < r_pc) begin
                        r_state <= S_IL_GEN;
                    end else begin
                        r_state <= S_IL_NEXT;
                    end
                end
                S_IL_GEN: begin
                    // jacobsthal order: count down inside a group, then open the next one
                    if (r_gval > r_gj1) begin
                        r_jo    <= CNT_W'(r_gval - GW'(1));
                        r_gval  <= r_gval - GW'(1);
                        r_state <= S_SR_INIT;
                    end else begin
                        r_gj1  <= r_gj2;
                        r_gj2  <= jn_c;
                        r_gval <= gmin_c;
                    end
                end
                S_SR_INIT: begin
                    r_lo    <= '0;
                    r_hi    <= hi_c;
                    r_state <= S_SR_KEY;
                end
                S_SR_KEY: r_state <= S_SR_TEST;
                S_SR_TEST: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= mid_c;
                        r_state <= S_SR_CMP;
                    end else begin
                        r_at    <= r_lo << r_lg;
                        r_src   <= a_key;
                        r_k     <= r_mlen;
                        r_state <= S_MV_TEST;
                    end
                end
                S_SR_CMP: begin
                    if (i_sts.lt_key) begin
                        r_hi <= r_mid;
                    end else begin
                        r_lo <= r_mid + CNT_W'(1);
                    end
                    r_state <= S_SR_TEST;
                end
                S_MV_TEST: begin
                    r_j     <= '0;
                    r_state <= (r_k > r_at) ? S_MV_WR : S_CPY0;
                end
                S_MV_WR: begin
                    r_k     <= a_km1;
                    r_state <= S_MV_TEST;
                end
                S_CPY0: r_state <= S_CPY1;
                S_CPY1: begin
                    r_j <= j_inc;
                    if (j_inc == r_span) begin
                        r_mlen  <= r_mlen + r_span;
                        r_ii    <= r_ii + CNT_W'(1);
                        r_state <= S_IL_LOOP;
                    end else begin
                        r_state <= S_CPY0;
                    end
                end
                S_IL_NEXT: begin
                    if (r_span == CNT_W'(1)) begin
                        r_k     <= '0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_span  <= r_span >> 1;
                        r_lg    <= r_lg - LG_W'(1);
                        r_state <= S_IL_START;
                    end
                end
                S_OUT_RD: r_state <= S_OUT_LD;
                S_OUT_LD: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_k + CNT_W'(1) == r_n) begin
                            r_count <= '0;
                            r_drop  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + CNT_W'(1);
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/merge_insertion_sorter.sv
// top level: ford-johnson merge-insertion sorter for up to 64 values
// Values load one word per cycle while the input is not stalled; the word marked last
// starts the sort, and input stalls until every sorted word of the run has been taken.
// The sort runs as a sequencer over two stores with one registered read port each:
// pair/swap passes compare the leading elements of each block pair and swap the pair
// element by element; each reinsertion level keeps the larger block of each pair in
// the main store, moves the smaller and any lone block to the pending store, keeps
// the tail, then for the pending blocks runs binary searches, shifts the main store
// up and copies each block in. A sorted word is loaded only once the last is taken.
// Values past 64 are dropped and flagged with overflow on every word of that run.
module merge_insertion_sorter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mis_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mis_pkg::t_out_word o_out_word
);
    import mis_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_word.last),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mis_dp u_dp (
        .i_clk      (i_clk),
        .i_value    (i_in_word.value),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

`ifndef ASSERT_OFF
    // no output while loading
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("output valid while input accepted");

    // a last word closes the run
    a_end_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_word.end_of_run) |=> !o_out_valid)
        else $error("output continues after end of run");

    // a last word starts the sort
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.last) |=> o_in_stall)
        else $error("input not stalled after last word");
`endif

endmodule
